// File: hdl/wlle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlle_pkg
// Shared constants, command type and lattice helper functions for the
// Z2 Wilson loop lattice engine.
// ----------------------------------------------------------------------------
package wlle_pkg;

  // lattice geometry
  localparam int LATTICE_SIZE = 8;
  localparam int NUM_AXES     = 3;
  localparam int MAX_LOOPS    = 9;
  localparam int COORD_IN_W   = 3;
  localparam int CW           = (LATTICE_SIZE > 2) ? $clog2(LATTICE_SIZE) : 1;
  localparam int SITES        = LATTICE_SIZE * LATTICE_SIZE * LATTICE_SIZE;
  localparam int SITE_W       = $clog2(SITES);
  localparam int PLAQ         = NUM_AXES * SITES;
  localparam int CNT_W        = $clog2(PLAQ + 1);
  localparam int SIZE_IN_W    = 4;
  localparam int SIZE_W       = SIZE_IN_W + 1;
  localparam int ENERGY_W     = 12;
  localparam int ENERGY_MAX   = (1 << (ENERGY_W - 1)) - 1;
  localparam int ENERGY_MIN   = -(1 << (ENERGY_W - 1));

  // op codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_LOOP   = 2'd1;
  localparam logic [1:0] OP_ENERGY = 2'd2;

  // plane codes, anything else is ZX
  localparam logic [1:0] PLANE_XY = 2'd1;
  localparam logic [1:0] PLANE_YZ = 2'd2;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef logic [CW-1:0] coord_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_LOOP,
    CMD_ENERGY
  } cmd_kind_t;

  // one classified item as it travels through the queue
  typedef struct packed {
    cmd_kind_t         kind;
    coord_t            x;
    coord_t            y;
    coord_t            z;
    logic [1:0]        axis;
    logic              neg;
    logic [1:0]        ax_a;
    logic [1:0]        ax_b;
    logic [SIZE_W-1:0] first;
    logic [SIZE_W-1:0] hi;
  } cmd_t;

  // input coordinate wrapped onto the lattice
  function automatic coord_t coord_wrap(input logic [COORD_IN_W-1:0] v);
    int r;
    r = int'(v);
    for (int i = 0; i < (1 << COORD_IN_W); i++) begin
      if (r >= LATTICE_SIZE) r = r - LATTICE_SIZE;
    end
    return coord_t'(r);
  endfunction

  function automatic coord_t coord_inc(input coord_t c);
    return (c == coord_t'(LATTICE_SIZE - 1)) ? coord_t'(0) : coord_t'(c + 1'b1);
  endfunction

  function automatic coord_t coord_dec(input coord_t c);
    return (c == coord_t'(0)) ? coord_t'(LATTICE_SIZE - 1) : coord_t'(c - 1'b1);
  endfunction

  function automatic logic [SITE_W-1:0] site_addr(input coord_t x, input coord_t y,
                                                  input coord_t z);
    int s;
    s = (int'(x) * LATTICE_SIZE + int'(y)) * LATTICE_SIZE + int'(z);
    return SITE_W'(s);
  endfunction

  // the two axes spanning a plane, packed as {a, b}
  function automatic logic [3:0] plane_axes(input logic [1:0] pl);
    logic [3:0] r;
    if (pl == PLANE_XY) r = {AXIS_X, AXIS_Y};
    else if (pl == PLANE_YZ) r = {AXIS_Y, AXIS_Z};
    else r = {AXIS_X, AXIS_Z};
    return r;
  endfunction

  // energy from the count of negative plaquettes, saturated to the field
  function automatic logic signed [ENERGY_W-1:0] energy_of(input logic [CNT_W-1:0] cnt);
    int e;
    e = 2 * int'(cnt) - PLAQ;
    if (e > ENERGY_MAX) e = ENERGY_MAX;
    if (e < ENERGY_MIN) e = ENERGY_MIN;
    return ENERGY_W'(e);
  endfunction

endpackage

// File: hdl/wlle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlle_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wlle_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/wlle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlle_front
// Takes items in, drops those that do nothing, decodes the rest into
// commands and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module wlle_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           op,
  input  logic [2:0]           x_coord,
  input  logic [2:0]           y_coord,
  input  logic [2:0]           z_coord,
  input  logic [1:0]           axis,
  input  logic                 link_negative,
  input  logic [1:0]           plane,
  input  logic [3:0]           first_size,
  input  logic [3:0]           last_size,
  input  logic                 clearing,
  output logic                 q_valid,
  output wlle_pkg::cmd_t       q_cmd,
  input  logic                 q_pop
);

  wlle_pkg::cmd_t                    fifo_mem [2];
  logic                              wr_ptr;
  logic                              rd_ptr;
  logic [1:0]                        count;
  logic                              keep;
  logic                              push;
  wlle_pkg::cmd_t                    cmd_in;
  logic [wlle_pkg::SIZE_W-1:0]       first_ext;
  logic [wlle_pkg::SIZE_W-1:0]       last_ext;
  logic [wlle_pkg::SIZE_W-1:0]       first_max;
  logic [3:0]                        axes;

  // classify and decode the incoming item
  always_comb begin
    first_ext = {1'b0, first_size};
    last_ext  = {1'b0, last_size};
    first_max = first_ext + wlle_pkg::SIZE_W'(wlle_pkg::MAX_LOOPS - 1);
    axes      = wlle_pkg::plane_axes(plane);

    cmd_in.kind  = wlle_pkg::CMD_WRITE;
    cmd_in.x     = wlle_pkg::coord_wrap(x_coord);
    cmd_in.y     = wlle_pkg::coord_wrap(y_coord);
    cmd_in.z     = wlle_pkg::coord_wrap(z_coord);
    cmd_in.axis  = axis;
    cmd_in.neg   = link_negative;
    cmd_in.ax_a  = axes[3:2];
    cmd_in.ax_b  = axes[1:0];
    cmd_in.first = first_ext;
    cmd_in.hi    = (last_ext > first_max) ? first_max : last_ext;

    keep = 1'b0;
    unique case (op)
      wlle_pkg::OP_WRITE: begin
        cmd_in.kind = wlle_pkg::CMD_WRITE;
        keep        = (axis == wlle_pkg::AXIS_X) || (axis == wlle_pkg::AXIS_Y) ||
                      (axis == wlle_pkg::AXIS_Z);
      end
      wlle_pkg::OP_LOOP: begin
        cmd_in.kind = wlle_pkg::CMD_LOOP;
        keep        = (last_size >= first_size);
      end
      wlle_pkg::OP_ENERGY: begin
        cmd_in.kind = wlle_pkg::CMD_ENERGY;
        keep        = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy    = clearing || (count == 2'd2);
  assign push    = start && !busy && keep;
  assign q_valid = (count != 2'd0);
  assign q_cmd   = fifo_mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_ptr] <= cmd_in;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      if (push && !q_pop) count <= count + 2'd1;
      else if (q_pop && !push) count <= count - 2'd1;
    end
  end

  // queue never overflows and is never popped empty
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (count != 2'd0))
    else $error("pop from empty queue");

endmodule

// File: hdl/wlle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlle_back
// Executes queued commands against the link store: link writes, square
// loop walks one link per cycle, and the plaquette sweep for energy.
// ----------------------------------------------------------------------------
module wlle_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  wlle_pkg::cmd_t                     q_cmd,
  output logic                               q_pop,
  output logic                               clearing,
  output logic                               done,
  output logic signed [1:0]                  loop_value,
  output logic [3:0]                         loop_size,
  output logic signed [wlle_pkg::ENERGY_W-1:0] energy,
  output logic                               last
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOP,
    ST_WALK,
    ST_DRAIN,
    ST_EOUT
  } state_t;

  state_t                        state;
  logic [wlle_pkg::SITE_W-1:0]   clr_addr;
  wlle_pkg::cmd_t                cmd;
  logic [wlle_pkg::SIZE_W-1:0]   n;
  wlle_pkg::coord_t              pos_x, pos_y, pos_z;
  logic [1:0]                    wa, wb;
  logic [1:0]                    side;
  wlle_pkg::coord_t              step;
  logic                          parity;
  logic                          rd_valid_q;
  logic [1:0]                    rd_axis_q;
  wlle_pkg::coord_t              e_x, e_y, e_z;
  logic [1:0]                    e_pl;
  logic [wlle_pkg::CNT_W-1:0]    e_cnt;

  logic [1:0]                    walk_ax;
  wlle_pkg::coord_t              mv_x, mv_y, mv_z;
  wlle_pkg::coord_t              rd_x, rd_y, rd_z;
  wlle_pkg::coord_t              n_m1;
  logic                          side_end;
  logic                          walk_end;
  logic                          n_big;
  logic                          n_is_hi;
  logic                          rd_data;
  logic                          par_fin;
  logic [wlle_pkg::SITE_W-1:0]   rd_addr;
  logic [wlle_pkg::SITE_W-1:0]   ram_waddr;
  logic                          ram_wdata;
  logic [wlle_pkg::NUM_AXES-1:0] ram_we;
  logic [wlle_pkg::NUM_AXES-1:0] ram_q;
  logic                          e_done;
  logic [1:0]                    nx_pl;
  wlle_pkg::coord_t              nx_x, nx_y, nx_z;
  logic [3:0]                    nx_axes;
  logic [3:0]                    zero_axes;

  assign clearing = (state == ST_CLEAR);
  assign q_pop    = (state == ST_IDLE) && q_valid;

  // walk address: move along the current side, read before or after the move
  always_comb begin
    walk_ax = side[0] ? wb : wa;
    mv_x = pos_x;
    mv_y = pos_y;
    mv_z = pos_z;
    unique case (walk_ax)
      wlle_pkg::AXIS_X: mv_x = side[1] ? wlle_pkg::coord_dec(pos_x) : wlle_pkg::coord_inc(pos_x);
      wlle_pkg::AXIS_Y: mv_y = side[1] ? wlle_pkg::coord_dec(pos_y) : wlle_pkg::coord_inc(pos_y);
      default:          mv_z = side[1] ? wlle_pkg::coord_dec(pos_z) : wlle_pkg::coord_inc(pos_z);
    endcase
    rd_x    = side[1] ? mv_x : pos_x;
    rd_y    = side[1] ? mv_y : pos_y;
    rd_z    = side[1] ? mv_z : pos_z;
    rd_addr = wlle_pkg::site_addr(rd_x, rd_y, rd_z);
  end

  // loop bookkeeping
  assign n_m1     = wlle_pkg::coord_t'(n - wlle_pkg::SIZE_W'(1));
  assign side_end = (step == n_m1);
  assign walk_end = side_end && (side == 2'd3);
  assign n_big    = (int'(n) >= wlle_pkg::LATTICE_SIZE);
  assign n_is_hi  = (n == cmd.hi);

  // link read data of the axis issued last cycle
  always_comb begin
    unique case (rd_axis_q)
      wlle_pkg::AXIS_X: rd_data = ram_q[0];
      wlle_pkg::AXIS_Y: rd_data = ram_q[1];
      default:          rd_data = ram_q[2];
    endcase
  end
  assign par_fin = parity ^ rd_data;

  // energy sweep: next plane and site
  always_comb begin
    e_done = (e_pl == 2'd2) &&
             (e_x == wlle_pkg::coord_t'(wlle_pkg::LATTICE_SIZE - 1)) &&
             (e_y == wlle_pkg::coord_t'(wlle_pkg::LATTICE_SIZE - 1)) &&
             (e_z == wlle_pkg::coord_t'(wlle_pkg::LATTICE_SIZE - 1));
    nx_pl = (e_pl == 2'd2) ? 2'd0 : e_pl + 2'd1;
    nx_x  = e_x;
    nx_y  = e_y;
    nx_z  = e_z;
    if (e_pl == 2'd2) begin
      nx_z = wlle_pkg::coord_inc(e_z);
      if (e_z == wlle_pkg::coord_t'(wlle_pkg::LATTICE_SIZE - 1)) begin
        nx_y = wlle_pkg::coord_inc(e_y);
        if (e_y == wlle_pkg::coord_t'(wlle_pkg::LATTICE_SIZE - 1)) begin
          nx_x = wlle_pkg::coord_inc(e_x);
        end
      end
    end
    nx_axes   = wlle_pkg::plane_axes(nx_pl);
    zero_axes = wlle_pkg::plane_axes(2'd0);
  end

  // store write port: clearing pass or link write
  always_comb begin
    ram_waddr = clearing ? clr_addr : wlle_pkg::site_addr(q_cmd.x, q_cmd.y, q_cmd.z);
    ram_wdata = clearing ? 1'b0 : q_cmd.neg;
  end

  for (genvar g = 0; g < wlle_pkg::NUM_AXES; g++) begin : g_store
    assign ram_we[g] = clearing ||
                       (q_pop && (q_cmd.kind == wlle_pkg::CMD_WRITE) && (q_cmd.axis == 2'(g)));

    wlle_ram #(
      .WIDTH (1),
      .DEPTH (wlle_pkg::SITES)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[g]),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_addr),
      .rdata (ram_q[g])
    );
  end

  // sequencer state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      done       <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      done       <= 1'b0;
      rd_valid_q <= (state == ST_WALK);
      rd_axis_q  <= walk_ax;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == wlle_pkg::SITE_W'(wlle_pkg::SITES - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            unique case (q_cmd.kind)
              wlle_pkg::CMD_LOOP: begin
                n     <= q_cmd.first;
                state <= ST_LOOP;
              end
              wlle_pkg::CMD_ENERGY: begin
                n      <= wlle_pkg::SIZE_W'(1);
                e_x    <= '0;
                e_y    <= '0;
                e_z    <= '0;
                e_pl   <= 2'd0;
                e_cnt  <= '0;
                pos_x  <= '0;
                pos_y  <= '0;
                pos_z  <= '0;
                wa     <= zero_axes[3:2];
                wb     <= zero_axes[1:0];
                side   <= 2'd0;
                step   <= '0;
                parity <= 1'b0;
                state  <= ST_WALK;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_LOOP: begin
          if ((n == '0) || n_big) begin
            // trivial loop, no links to read
            done       <= 1'b1;
            loop_value <= n_big ? 2'sb00 : 2'sb01;
            loop_size  <= n[3:0];
            energy     <= '0;
            last       <= n_is_hi;
            if (n_is_hi) state <= ST_IDLE;
            else n <= n + 1'b1;
          end else begin
            pos_x  <= cmd.x;
            pos_y  <= cmd.y;
            pos_z  <= cmd.z;
            wa     <= cmd.ax_a;
            wb     <= cmd.ax_b;
            side   <= 2'd0;
            step   <= '0;
            parity <= 1'b0;
            state  <= ST_WALK;
          end
        end
        ST_WALK: begin
          parity <= parity ^ (rd_valid_q & rd_data);
          pos_x  <= mv_x;
          pos_y  <= mv_y;
          pos_z  <= mv_z;
          if (side_end) begin
            step <= '0;
            side <= side + 2'd1;
          end else begin
            step <= step + 1'b1;
          end
          if (walk_end) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (cmd.kind == wlle_pkg::CMD_ENERGY) begin
            e_cnt <= e_cnt + wlle_pkg::CNT_W'(par_fin);
            if (e_done) begin
              state <= ST_EOUT;
            end else begin
              e_pl   <= nx_pl;
              e_x    <= nx_x;
              e_y    <= nx_y;
              e_z    <= nx_z;
              pos_x  <= nx_x;
              pos_y  <= nx_y;
              pos_z  <= nx_z;
              wa     <= nx_axes[3:2];
              wb     <= nx_axes[1:0];
              side   <= 2'd0;
              step   <= '0;
              parity <= 1'b0;
              state  <= ST_WALK;
            end
          end else begin
            done       <= 1'b1;
            loop_value <= par_fin ? 2'sb11 : 2'sb01;
            loop_size  <= n[3:0];
            energy     <= '0;
            last       <= n_is_hi;
            if (n_is_hi) begin
              state <= ST_IDLE;
            end else begin
              n     <= n + 1'b1;
              state <= ST_LOOP;
            end
          end
        end
        ST_EOUT: begin
          done       <= 1'b1;
          loop_value <= 2'sb00;
          loop_size  <= '0;
          energy     <= wlle_pkg::energy_of(e_cnt);
          last       <= 1'b1;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // walk step counter stays inside the side length
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (step <= n_m1))
    else $error("walk step beyond side length");
  // the drain cycle only ever follows the walk
  a_drain_after_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> ($past(state) == ST_WALK))
    else $error("drain without walk");
  // the final result of a query leaves the sequencer idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (done && last) |-> (state == ST_IDLE))
    else $error("sequencer active after final result");

endmodule

// File: hdl/wilson_loop_lattice_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wilson_loop_lattice_engine_top
// Z2 lattice gauge engine: link store, Wilson loop queries and plaquette
// energy on a periodic cubic lattice.
// ----------------------------------------------------------------------------
// After reset the link store is swept to all +1 for every site (one site of
// all three axes per cycle) with busy held high. Items are taken when start
// is high and busy is low; a two-entry command queue lets up to two items be
// taken while the engine works. The engine reads one link per cycle from the
// store. Every command first leaves the queue, which is all a write needs;
// after that a loop walks the square of each size in turn, a side of 0 or of
// the lattice size and above reads no links, and an energy query walks every
// plaquette in turn and then gives its result.
// Each result appears on the result ports for exactly one cycle with done
// high; the receiver cannot stall the block, so it must take every result on
// that cycle.
// ----------------------------------------------------------------------------
module wilson_loop_lattice_engine_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            op,
  input  logic [2:0]                            x_coord,
  input  logic [2:0]                            y_coord,
  input  logic [2:0]                            z_coord,
  input  logic [1:0]                            axis,
  input  logic                                  link_negative,
  input  logic [1:0]                            plane,
  input  logic [3:0]                            first_size,
  input  logic [3:0]                            last_size,
  output logic                                  done,
  output logic signed [1:0]                     loop_value,
  output logic [3:0]                            loop_size,
  output logic signed [wlle_pkg::ENERGY_W-1:0]  energy,
  output logic                                  last
);

  logic           q_valid;
  wlle_pkg::cmd_t q_cmd;
  logic           q_pop;
  logic           clearing;

  // front end: accept, classify, queue
  wlle_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .z_coord       (z_coord),
    .axis          (axis),
    .link_negative (link_negative),
    .plane         (plane),
    .first_size    (first_size),
    .last_size     (last_size),
    .clearing      (clearing),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  // back end: link store and loop sequencer
  wlle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .done       (done),
    .loop_value (loop_value),
    .loop_size  (loop_size),
    .energy     (energy),
    .last       (last)
  );

endmodule
